### sv/pru_pkg.sv
// Shared types and constants for the pixel replicate upscaler.
// Beat payload structs, register field widths and register indexes.
package pru_pkg;

    localparam int IW_W          = 13;
    localparam int SF_W          = 5;
    localparam int PIX_W         = 24;
    localparam int APB_DW        = 32;
    localparam int APB_AW        = 3;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_SCALE_DEF = 16;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_REPLAY  = 1'b1;

    localparam logic REG_IDX_WIDTH = 1'b0;
    localparam logic REG_IDX_SCALE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       rejected;
        logic       last;
    } beat_t;

endpackage

### sv/pru_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module pru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pixel_replicate_upscaler.sv
// Pixel replicate upscaler top level: line buffer RAM, issue stage, beat emitter, APB regs.
// Depends on pru_pkg and pru_ram.
// An item is held in the issue stage until the emitter is free; the emitter drives its first beat.
// Throughput: effective scale (1..MAX_SCALE) beats per item; a rejected item gives one beat.
// The emitter repeats one pixel per cycle while beat_ready is high, which sets the item rate.
// Reset clears phase, column, pass count, pipeline valids and registers (width 1, scale 1).
// The line buffer is not cleared and no init pass runs after reset.
module pixel_replicate_upscaler
#(
    parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = pru_pkg::MAX_SCALE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pru_pkg::item_t              item,
    input  logic                        item_valid,
    output logic                        item_ready,
    output pru_pkg::beat_t              beat,
    output logic                        beat_valid,
    input  logic                        beat_ready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pru_pkg::APB_AW-1:0]  paddr,
    input  logic [pru_pkg::APB_DW-1:0]  pwdata,
    output logic [pru_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    import pru_pkg::*;

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW  = (AW + 1 > IW_W) ? AW + 1 : IW_W;
    localparam int KW  = ($clog2(MAX_SCALE + 1) > SF_W) ? $clog2(MAX_SCALE + 1) : SF_W;
    localparam int CPW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             from_ram;
        logic             rejected;
        logic             row_done;
        logic [1:0]       pad;
        logic [KW-1:0]    beats;
    } job_t;

    logic [IW_W-1:0] iw_reg;
    logic [SF_W-1:0] sf_reg;
    logic [AW-1:0]   column_reg, column_next;
    logic [CPW-1:0]  copy_reg, copy_next;
    logic            phase_reg, phase_next;
    logic            s1_valid_reg, s1_valid_next;
    job_t            s1_reg, s1_next;
    logic            e_valid_reg, e_valid_next;
    job_t            e_reg, e_next;

    logic             item_fire, beat_fire, e_last, e_free, s1_move;
    logic             reject, row_done, pass_done, apb_write;
    logic [XW-1:0]    col_p1;
    logic [KW-1:0]    eff_s, copy_p1;
    logic [1:0]       w_lo;
    logic [3:0]       pad_prod;
    logic [PIX_W-1:0] cap_pix, ram_rdata;

    // APB registers
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_WIDTH: prdata = APB_DW'(iw_reg);
            REG_IDX_SCALE: prdata = APB_DW'(sf_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= IW_W'(1);
            sf_reg <= SF_W'(1);
        end
        else if (apb_write)
        begin
            unique case (paddr[2])
                REG_IDX_WIDTH: iw_reg <= pwdata[IW_W-1:0];
                REG_IDX_SCALE: sf_reg <= pwdata[SF_W-1:0];
                default:       iw_reg <= iw_reg;
            endcase
        end
    end

    // Effective config and row/pass decisions
    always_comb
    begin
        if (sf_reg == '0)
            eff_s = KW'(1);
        else if (KW'(sf_reg) > KW'(MAX_SCALE))
            eff_s = KW'(MAX_SCALE);
        else
            eff_s = KW'(sf_reg);

        if (iw_reg == '0)
            w_lo = 2'd1;
        else if (XW'(iw_reg) > XW'(MAX_WIDTH))
            w_lo = 2'(MAX_WIDTH);
        else
            w_lo = iw_reg[1:0];
    end

    assign col_p1    = XW'(column_reg) + XW'(1);
    assign row_done  = (col_p1 >= XW'(iw_reg)) || (col_p1 >= XW'(MAX_WIDTH));
    assign copy_p1   = KW'(copy_reg) + KW'(1);
    assign pass_done = copy_p1 >= eff_s;
    assign pad_prod  = 4'(w_lo) * 4'(eff_s[1:0]);
    assign reject    = item.mode != phase_reg;
    assign cap_pix   = {item.red, item.green, item.blue};

    // Handshake
    assign beat_fire  = beat_valid && beat_ready;
    assign e_last     = e_reg.beats == KW'(1);
    assign e_free     = !e_valid_reg || (beat_fire && e_last);
    assign s1_move    = s1_valid_reg && e_free;
    assign item_ready = !s1_valid_reg || e_free;
    assign item_fire  = item_valid && item_ready;

    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (item_fire && !reject && (item.mode == MODE_CAPTURE)),
        .waddr (column_reg),
        .wdata (cap_pix),
        .re    (item_fire && !reject && (item.mode == MODE_REPLAY)),
        .raddr (column_reg),
        .rdata (ram_rdata)
    );

    // Scan state
    always_comb
    begin
        column_next = column_reg;
        copy_next   = copy_reg;
        phase_next  = phase_reg;
        if (item_fire && !reject)
        begin
            if (!row_done)
            begin
                column_next = column_reg + AW'(1);
            end
            else
            begin
                column_next = '0;
                if (phase_reg == MODE_CAPTURE)
                begin
                    if (eff_s > KW'(1))
                    begin
                        phase_next = MODE_REPLAY;
                        copy_next  = CPW'(1);
                    end
                end
                else if (pass_done)
                begin
                    phase_next = MODE_CAPTURE;
                    copy_next  = '0;
                end
                else
                begin
                    copy_next = copy_reg + CPW'(1);
                end
            end
        end
    end

    // Issue stage and emitter
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (item_fire)
        begin
            s1_valid_next     = 1'b1;
            s1_next.pixel     = reject ? '0 : cap_pix;
            s1_next.from_ram  = !reject && (item.mode == MODE_REPLAY);
            s1_next.rejected  = reject;
            s1_next.row_done  = !reject && row_done;
            s1_next.pad       = reject ? 2'd0 : pad_prod[1:0];
            s1_next.beats     = reject ? KW'(1) : eff_s;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        e_valid_next = e_valid_reg;
        e_next       = e_reg;
        if (s1_move)
        begin
            e_valid_next = 1'b1;
            e_next       = s1_reg;
            if (s1_reg.from_ram)
            begin
                e_next.pixel = ram_rdata;
            end
        end
        else if (beat_fire)
        begin
            if (e_last)
                e_valid_next = 1'b0;
            else
                e_next.beats = e_reg.beats - KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            copy_reg     <= '0;
            phase_reg    <= MODE_CAPTURE;
            s1_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            copy_reg     <= copy_next;
            phase_reg    <= phase_next;
            s1_valid_reg <= s1_valid_next;
            e_valid_reg  <= e_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        e_reg  <= e_next;
    end

    // Beat payload
    assign beat_valid          = e_valid_reg;
    assign beat.out_blue       = e_reg.pixel[7:0];
    assign beat.out_green      = e_reg.pixel[15:8];
    assign beat.out_red        = e_reg.pixel[23:16];
    assign beat.row_end        = e_last && e_reg.row_done;
    assign beat.pad_bytes      = (e_last && e_reg.row_done) ? e_reg.pad : 2'd0;
    assign beat.rejected       = e_reg.rejected;
    assign beat.last           = e_last;

    a_reject_next: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && reject) |=> (s1_valid_reg && s1_reg.rejected))
        else $error("rejected item not staged");

    a_copy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == MODE_CAPTURE) |-> (copy_reg == '0))
        else $error("pass count nonzero in capture phase");

    a_beats_nz: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (e_reg.beats != '0))
        else $error("emitter holds zero beats");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !e_free) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("issue stage lost a stalled item");

endmodule
